### src/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared widths, register indexes and the result beat type of the graph
// m-coloring search block.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned ROW_W   = 32;  // adjacency row width
  localparam int unsigned IDX_W   = 5;   // row / vertex index field width
  localparam int unsigned COLOR_W = 6;   // color field width
  localparam int unsigned CFG_W   = 6;   // configuration data width
  localparam int unsigned MASK_W  = 1 << COLOR_W;  // one bit per color code

  // configuration register indexes
  localparam logic CFG_NUM_VERTICES = 1'b0;
  localparam logic CFG_NUM_COLORS   = 1'b1;

  // one result beat
  typedef struct packed {
    logic [IDX_W-1:0]   vertex_index;
    logic [COLOR_W-1:0] vertex_color;
    logic               found;
    logic               last_result;
  } res_t;

endpackage

### src/gmc_ram.sv
// ----------------------------------------------------------------------------
// gmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module gmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/gmc_search.sv
// ----------------------------------------------------------------------------
// gmc_search
// Sequencer of the coloring search: stores rows, clears the color memory,
// walks the vertices with a read-modify-write loop over the color memory,
// and streams the coloring out.
// ----------------------------------------------------------------------------
module gmc_search
  import gmc_pkg::*;
#(
  parameter int unsigned MAX_VERTEX = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [IDX_W-1:0]                            row_index_i,
  input  logic [ROW_W-1:0]                            row_bits_i,
  input  logic [CFG_W-1:0]                            num_vertices_i,
  input  logic [CFG_W-1:0]                            num_colors_i,
  output logic                                        busy_o,
  output logic                                        adj_we_o,
  output logic [$clog2((MAX_VERTEX < 32) ? MAX_VERTEX : 32)-1:0] adj_waddr_o,
  output logic [ROW_W-1:0]                            adj_wdata_o,
  output logic [$clog2((MAX_VERTEX < 32) ? MAX_VERTEX : 32)-1:0] adj_raddr_o,
  input  logic [ROW_W-1:0]                            adj_rdata_i,
  output logic                                        col_we_o,
  output logic [$clog2((MAX_VERTEX < 32) ? MAX_VERTEX : 32)-1:0] col_waddr_o,
  output logic [COLOR_W-1:0]                          col_wdata_o,
  output logic [$clog2((MAX_VERTEX < 32) ? MAX_VERTEX : 32)-1:0] col_raddr_o,
  input  logic [COLOR_W-1:0]                          col_rdata_i,
  output logic                                        res_valid_o,
  output res_t                                        res_o
);

  localparam int unsigned LIM = (MAX_VERTEX < 32) ? MAX_VERTEX : 32;
  localparam int unsigned VW  = $clog2(LIM);
  localparam int unsigned NW  = VW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_VLOAD,
    ST_VCAP,
    ST_SCAN,
    ST_PICK,
    ST_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [NW-1:0]       n_q, n_d;
  logic [COLOR_W-1:0]  m_q, m_d;
  logic [NW-1:0]       v_q, v_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [NW-1:0]       pidx_q, pidx_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COLOR_W:0]    c_q, c_d;
  logic [MASK_W-1:0]   mask_q, mask_d;

  logic [CFG_W-1:0]    n_eff;
  logic                row_ok;
  logic                row_last;
  logic                accept;

  // clamp the vertex count to 1..LIM
  always_comb begin
    n_eff = num_vertices_i;
    if (num_vertices_i == '0) begin
      n_eff = CFG_W'(1);
    end else if (num_vertices_i > CFG_W'(LIM)) begin
      n_eff = CFG_W'(LIM);
    end
  end

  assign accept   = start_i && (state_q == ST_IDLE);
  assign row_ok   = {2'b00, row_index_i} < 7'(MAX_VERTEX);
  assign row_last = {1'b0, row_index_i} == (n_eff - CFG_W'(1));

  assign busy_o      = (state_q != ST_IDLE);
  assign adj_we_o    = accept && row_ok;
  assign adj_waddr_o = row_index_i[VW-1:0];
  assign adj_wdata_o = row_bits_i;
  assign adj_raddr_o = v_q[VW-1:0];

  // next state, memory requests and result beat
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    m_d         = m_q;
    v_d         = v_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    row_d       = row_q;
    c_d         = c_q;
    mask_d      = mask_q;
    col_we_o    = 1'b0;
    col_waddr_o = v_q[VW-1:0];
    col_wdata_o = '0;
    col_raddr_o = v_q[VW-1:0];
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      ST_IDLE: begin
        // store the row; the last row in use launches the search
        if (accept && row_ok && row_last) begin
          n_d     = NW'(n_eff);
          m_d     = num_colors_i;
          cnt_d   = '0;
          state_d = ST_CLEAR;
        end
      end

      ST_CLEAR: begin
        // zero one color entry a cycle
        col_we_o    = 1'b1;
        col_waddr_o = cnt_q[VW-1:0];
        cnt_d       = cnt_q + NW'(1);
        if (cnt_q == n_q - NW'(1)) begin
          v_d     = '0;
          state_d = ST_VLOAD;
        end
      end

      ST_VLOAD: begin
        // read row and current color of vertex v
        state_d = ST_VCAP;
      end

      ST_VCAP: begin
        row_d   = adj_rdata_i;
        c_d     = {1'b0, col_rdata_i} + (COLOR_W+1)'(1);
        mask_d  = '0;
        cnt_d   = '0;
        pend_d  = 1'b0;
        state_d = (v_q == '0) ? ST_PICK : ST_SCAN;
      end

      ST_SCAN: begin
        // gather colors of earlier neighbors, one read issued a cycle
        col_raddr_o = cnt_q[VW-1:0];
        if (cnt_q < v_q) begin
          pend_d = row_q[cnt_q[VW-1:0]];
          cnt_d  = cnt_q + NW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mask_d[col_rdata_i] = 1'b1;
        end
        if ((cnt_q == v_q) && !pend_q) begin
          state_d = ST_PICK;
        end
      end

      ST_PICK: begin
        // try one candidate color a cycle
        col_waddr_o = v_q[VW-1:0];
        if (c_q > {1'b0, m_q}) begin
          // no color left: uncolor and backtrack
          col_we_o = 1'b1;
          if (v_q == '0) begin
            res_valid_o       = 1'b1;
            res_o.last_result = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            v_d     = v_q - NW'(1);
            state_d = ST_VLOAD;
          end
        end else if (!mask_q[c_q[COLOR_W-1:0]]) begin
          // safe: place and advance
          col_we_o    = 1'b1;
          col_wdata_o = c_q[COLOR_W-1:0];
          v_d         = v_q + NW'(1);
          if (v_q + NW'(1) == n_q) begin
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_VLOAD;
          end
        end else begin
          c_d = c_q + (COLOR_W+1)'(1);
        end
      end

      ST_OUT: begin
        // stream the coloring, one read issued a cycle
        col_raddr_o = cnt_q[VW-1:0];
        if (cnt_q < n_q) begin
          pend_d = 1'b1;
          pidx_d = cnt_q;
          cnt_d  = cnt_q + NW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          res_valid_o        = 1'b1;
          res_o.vertex_index = IDX_W'(pidx_q);
          res_o.vertex_color = col_rdata_i;
          res_o.found        = 1'b1;
          res_o.last_result  = (pidx_q == n_q - NW'(1));
          if (pidx_q == n_q - NW'(1)) begin
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      v_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      v_q     <= v_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    pidx_q <= pidx_d;
    row_q  <= row_d;
    c_q    <= c_d;
    mask_q <= mask_d;
  end

endmodule

### src/graph_m_coloring_search.sv
// ----------------------------------------------------------------------------
// graph_m_coloring_search
// Graph m-coloring by depth-first backtracking over a stored adjacency matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Load rows with start; a beat is taken when start is high and busy is low.
//   row_index_i selects the vertex, row_bits_i carries its neighbors. The row
//   of vertex num_vertices-1 launches the search; busy falls in the cycle in
//   which the last result shows on strobe. Results come on strobe, one beat
//   per cycle, one cycle each; the receiver cannot hold them off. On success
//   there is one beat per vertex in vertex order, the last flagged by
//   last_result_o; on failure a single beat with found_o low. A search first
//   clears the color memory. Each vertex visit then reads the row and color,
//   at vertex v > 0 scans the earlier vertices for the colors of its neighbors,
//   and tries candidate colors in turn; when none is left it uncolors the
//   vertex and backtracks. The coloring is then read out; each beat is
//   registered before it shows. The count of visits depends on the graph and
//   may grow exponentially. Configuration (num_vertices, num_colors) is
//   written with cfg_we_i while busy is low. Reset returns both registers to 1
//   and the sequencer to idle; adjacency rows hold no value until written.
// ----------------------------------------------------------------------------
module graph_m_coloring_search
  import gmc_pkg::*;
#(
  parameter int unsigned MAX_VERTEX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   row_index_i,
  input  logic [ROW_W-1:0]   row_bits_i,
  output logic               strobe,
  output logic [IDX_W-1:0]   vertex_index_o,
  output logic [COLOR_W-1:0] vertex_color_o,
  output logic               found_o,
  output logic               last_result_o
);

  localparam int unsigned LIM = (MAX_VERTEX < 32) ? MAX_VERTEX : 32;
  localparam int unsigned VW  = $clog2(LIM);

  logic [CFG_W-1:0]   num_vertices_q;
  logic [CFG_W-1:0]   num_colors_q;

  logic               adj_we;
  logic [VW-1:0]      adj_waddr;
  logic [ROW_W-1:0]   adj_wdata;
  logic [VW-1:0]      adj_raddr;
  logic [ROW_W-1:0]   adj_rdata;
  logic               col_we;
  logic [VW-1:0]      col_waddr;
  logic [COLOR_W-1:0] col_wdata;
  logic [VW-1:0]      col_raddr;
  logic [COLOR_W-1:0] col_rdata;

  logic               res_valid;
  res_t               res;
  logic               strobe_q;
  res_t               res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vertices_q <= CFG_W'(1);
      num_colors_q   <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_VERTICES: num_vertices_q <= cfg_data_i;
        CFG_NUM_COLORS:   num_colors_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  gmc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (LIM)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gmc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LIM)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  gmc_search #(
    .MAX_VERTEX (MAX_VERTEX)
  ) u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .row_index_i    (row_index_i),
    .row_bits_i     (row_bits_i),
    .num_vertices_i (num_vertices_q),
    .num_colors_i   (num_colors_q),
    .busy_o         (busy),
    .adj_we_o       (adj_we),
    .adj_waddr_o    (adj_waddr),
    .adj_wdata_o    (adj_wdata),
    .adj_raddr_o    (adj_raddr),
    .adj_rdata_i    (adj_rdata),
    .col_we_o       (col_we),
    .col_waddr_o    (col_waddr),
    .col_wdata_o    (col_wdata),
    .col_raddr_o    (col_raddr),
    .col_rdata_i    (col_rdata),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // register the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign strobe         = strobe_q;
  assign vertex_index_o = res_q.vertex_index;
  assign vertex_color_o = res_q.vertex_color;
  assign found_o        = res_q.found;
  assign last_result_o  = res_q.last_result;

endmodule

### src/gmc_checker.sv
// ----------------------------------------------------------------------------
// gmc_checker
// Port-level checks of the graph m-coloring search block, bound to the top.
// ----------------------------------------------------------------------------
module gmc_checker
  import gmc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               strobe,
  input logic [IDX_W-1:0]   vertex_index_o,
  input logic [COLOR_W-1:0] vertex_color_o,
  input logic               found_o,
  input logic               last_result_o
);

  // a result beat only follows a busy cycle
  a_beat_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(busy))
    else $error("result beat without a running search");

  // a failure beat is the only beat and carries zeros
  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !found_o |-> last_result_o && vertex_index_o == '0 &&
                           vertex_color_o == '0)
    else $error("malformed failure beat");

  // every reported color is a real color
  a_color_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && found_o |-> vertex_color_o != '0)
    else $error("success beat with uncolored vertex");

  // a coloring streams without gaps, vertices in order
  a_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && found_o && !last_result_o |=>
      strobe && found_o && vertex_index_o == $past(vertex_index_o) + IDX_W'(1))
    else $error("gap or misordered vertex in coloring");

endmodule

bind graph_m_coloring_search gmc_checker u_gmc_checker (.*);
